// File: design/rk4do_pkg.sv
// ----------------------------------------------------------------------------
// rk4do_pkg
// Shared types and constants of the RK4 damped-oscillator stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package rk4do_pkg;

    // Fixed field widths.
    localparam int unsigned DATA_W  = 32;  // x, y and v, signed fixed point
    localparam int unsigned H_W     = 17;  // step size, unsigned
    localparam int unsigned CNT_W   = 16;  // step index and step count
    localparam int unsigned DV_W    = 35;  // -2v - 5y, exact
    localparam int unsigned PROD_W  = DV_W + H_W + 1;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned PDATA_W = 32;

    // The divide-by-six units retire this many quotient bits per cycle.
    localparam int unsigned DIV_DIGIT_W = 8;

    // Register reset values.
    localparam logic [H_W-1:0]    STEP_SIZE_RST  = 17'd6554;
    localparam logic [DATA_W-1:0] START_X_RST    = 32'd0;
    localparam logic [DATA_W-1:0] START_Y_RST    = 32'd0;
    localparam logic [DATA_W-1:0] START_V_RST    = 32'd65536;
    localparam logic [CNT_W-1:0]  STEP_COUNT_RST = 16'd0;

    // Register map, word index.
    typedef enum logic [2:0] {
        REG_STEP_SIZE  = 3'd0,
        REG_START_X    = 3'd1,
        REG_START_Y    = 3'd2,
        REG_START_V    = 3'd3,
        REG_STEP_COUNT = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARG,
        ST_MULV,
        ST_MULD,
        ST_KCAP,
        ST_ACC,
        ST_DIVS,
        ST_DIVW,
        ST_UPD
    } state_t;

    typedef enum logic [1:0] {
        STG_K1 = 2'd0,
        STG_K2 = 2'd1,
        STG_K3 = 2'd2,
        STG_K4 = 2'd3
    } stage_t;

    typedef struct packed {
        logic load;        // item accepted: reload on restart, clear work registers
        logic arg;         // form the stage arguments with saturation
        logic arg_full;    // add the whole k instead of half of it
        logic acc_en;      // add the held k values into the weighted sums
        logic acc_double;  // the held k values carry weight two
        logic mulv;        // multiply h by the velocity argument
        logic muld;        // multiply h by the derivative of v; capture k for y
        logic kcap;        // capture k for v
        logic div_start;   // start both divide-by-six units
        logic commit;      // write the result register and the new state
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// File: design/rk4_damped_oscillator_step_top.sv
// ----------------------------------------------------------------------------
// rk4_damped_oscillator_step_top
// Fixed-point RK4 stepper for y'' + 2y' + 5y = 0 with an APB register port.
// ----------------------------------------------------------------------------
// Each input transfer is one tick: when restart is set the state is first
// reloaded from start_x, start_y and start_v and the step index cleared; the
// block then returns the current x, y and v, a final_point flag (step index
// equal to step_count) and an overflow flag for the RK4 step of size h that
// it then applies. Registers sit at byte addresses 0, 4, 8, 12 and 16:
// step_size, start_x, start_y, start_v, step_count. Each of the four stages
// steps through the argument, two multiply and k capture states on the
// single 35 x 18 multiplier, and the two divide-by-six units retire eight
// quotient bits per cycle. The block takes one item at a time; the result
// waits in an output register, so the next item is accepted as soon as the
// previous result has been captured there.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_damped_oscillator_step_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic        [rk4do_pkg::ADDR_W-1:0]   paddr,
    input  wire logic        [rk4do_pkg::PDATA_W-1:0]  pwdata,
    output logic             [rk4do_pkg::PDATA_W-1:0]  prdata,
    output logic                                       pready,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  restart,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed      [rk4do_pkg::DATA_W-1:0]   point_x,
    output logic signed      [rk4do_pkg::DATA_W-1:0]   point_y,
    output logic signed      [rk4do_pkg::DATA_W-1:0]   point_v,
    output logic                                       final_point,
    output logic                                       overflow
);
    import rk4do_pkg::*;

    logic [H_W-1:0]    step_size_reg;
    logic [DATA_W-1:0] start_x_reg, start_y_reg, start_v_reg;
    logic [CNT_W-1:0]  step_count_reg;

    logic       cfg_wr;
    reg_idx_t   reg_idx;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= STEP_SIZE_RST;
            start_x_reg    <= START_X_RST;
            start_y_reg    <= START_Y_RST;
            start_v_reg    <= START_V_RST;
            step_count_reg <= STEP_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_STEP_SIZE:  step_size_reg  <= pwdata[H_W-1:0];
                REG_START_X:    start_x_reg    <= pwdata[DATA_W-1:0];
                REG_START_Y:    start_y_reg    <= pwdata[DATA_W-1:0];
                REG_START_V:    start_v_reg    <= pwdata[DATA_W-1:0];
                REG_STEP_COUNT: step_count_reg <= pwdata[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_STEP_SIZE:  prdata = PDATA_W'(step_size_reg);
            REG_START_X:    prdata = PDATA_W'(start_x_reg);
            REG_START_Y:    prdata = PDATA_W'(start_y_reg);
            REG_START_V:    prdata = PDATA_W'(start_v_reg);
            REG_STEP_COUNT: prdata = PDATA_W'(step_count_reg);
            default:        prdata = '0;
        endcase
    end

    rk4do_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rk4do_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .restart     (restart),
        .step_size   (step_size_reg),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .start_v     (start_v_reg),
        .step_count  (step_count_reg),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_v     (point_v),
        .final_point (final_point),
        .overflow    (overflow)
    );

endmodule

`default_nettype wire

// File: design/rk4do_div6.sv
// ----------------------------------------------------------------------------
// rk4do_div6
// Digit-serial signed divide by six, rounding to nearest with ties away
// from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4do_div6 #(
    parameter int unsigned OPND_W = 40
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [OPND_W-1:0] dividend,
    output logic      [OPND_W-1:0] quotient,
    output logic                   negative,
    output logic                   busy
);
    import rk4do_pkg::*;

    localparam int unsigned DIGITS = (OPND_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W;
    localparam int unsigned PAD_W  = DIGITS * DIV_DIGIT_W;
    localparam int unsigned STEP_W = $clog2(DIGITS + 1);
    localparam logic [3:0]  DIVISOR = 4'd6;

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [PAD_W-1:0]  mag_reg;
    logic [PAD_W-1:0]  quo_reg;
    logic [2:0]        rem_reg;
    logic              neg_reg;

    logic [OPND_W-1:0]      mag_start;
    logic [DIV_DIGIT_W-1:0] digit;
    logic [2:0]             rem_next;

    // |s| + 3 in one add: for negative s this is ~s + 4.
    assign mag_start = (dividend[OPND_W-1] ? ~dividend : dividend)
                     + (dividend[OPND_W-1] ? OPND_W'(4) : OPND_W'(3));

    always_comb
    begin
        logic [2:0] r;
        logic [3:0] trial;
        r     = rem_reg;
        digit = '0;
        for (int i = 0; i < DIV_DIGIT_W; i++)
        begin
            trial = {r, mag_reg[PAD_W-1-i]};
            if (trial >= DIVISOR)
            begin
                r = 3'(trial - DIVISOR);
                digit[DIV_DIGIT_W-1-i] = 1'b1;
            end
            else
            begin
                r = trial[2:0];
            end
        end
        rem_next = r;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
            cnt_next = STEP_W'(DIGITS);
        else if (busy)
            cnt_next = cnt_reg - STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= PAD_W'(mag_start);
            quo_reg <= '0;
            rem_reg <= '0;
            neg_reg <= dividend[OPND_W-1];
        end
        else if (busy)
        begin
            mag_reg <= {mag_reg[PAD_W-DIV_DIGIT_W-1:0], {DIV_DIGIT_W{1'b0}}};
            quo_reg <= {quo_reg[PAD_W-DIV_DIGIT_W-1:0], digit};
            rem_reg <= rem_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg[OPND_W-1:0];
    assign negative = neg_reg;

endmodule

`default_nettype wire

// File: design/rk4do_dpath.sv
// ----------------------------------------------------------------------------
// rk4do_dpath
// Datapath of the RK4 stepper: state, stage arguments, shared multiplier,
// weighted sums, divide-by-six units and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4do_dpath #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rk4do_pkg::dp_cmd_t                cmd,
    output rk4do_pkg::dp_status_t                  status,
    input  wire logic                              restart,
    input  wire logic        [rk4do_pkg::H_W-1:0]    step_size,
    input  wire logic signed [rk4do_pkg::DATA_W-1:0] start_x,
    input  wire logic signed [rk4do_pkg::DATA_W-1:0] start_y,
    input  wire logic signed [rk4do_pkg::DATA_W-1:0] start_v,
    input  wire logic        [rk4do_pkg::CNT_W-1:0]  step_count,
    output logic signed      [rk4do_pkg::DATA_W-1:0] point_x,
    output logic signed      [rk4do_pkg::DATA_W-1:0] point_y,
    output logic signed      [rk4do_pkg::DATA_W-1:0] point_v,
    output logic                                   final_point,
    output logic                                   overflow
);
    import rk4do_pkg::*;

    localparam int unsigned K_W     = PROD_W - FRAC_BITS;
    localparam int unsigned ACC_W   = K_W + 3;
    localparam int unsigned ACC_EXT = ACC_W - K_W;
    localparam int unsigned BASE_W  = (ACC_W > DATA_W) ? ACC_W : DATA_W;
    localparam int unsigned SAT_W   = BASE_W + 2;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic [SAT_W-1:0] ext_d(input logic [DATA_W-1:0] a);
        return {{(SAT_W-DATA_W){a[DATA_W-1]}}, a};
    endfunction

    function automatic logic [SAT_W-1:0] ext_k(input logic [K_W-1:0] a);
        return {{(SAT_W-K_W){a[K_W-1]}}, a};
    endfunction

    function automatic logic fits(input logic [SAT_W-1:0] a);
        return (&a[SAT_W-1:DATA_W-1]) || !(|a[SAT_W-1:DATA_W-1]);
    endfunction

    function automatic logic [DATA_W-1:0] sat(input logic [SAT_W-1:0] a);
        logic [DATA_W-1:0] r;
        if (fits(a))
            r = a[DATA_W-1:0];
        else if (a[SAT_W-1])
            r = SAT_MIN;
        else
            r = SAT_MAX;
        return r;
    endfunction

    // Architectural state.
    logic [DATA_W-1:0] x_reg, y_reg, v_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              ovf_reg;

    // Work registers.
    logic [DATA_W-1:0] ys_reg, vs_reg;
    logic [DV_W-1:0]   dv_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [K_W-1:0]    ky_reg, kv_reg;
    logic [ACC_W-1:0]  accy_reg, accv_reg;

    // Result register.
    logic [DATA_W-1:0] point_x_reg, point_y_reg, point_v_reg;
    logic              final_reg, overflow_reg;

    logic [K_W-1:0]    off_y, off_v;
    logic [SAT_W-1:0]  arg_y, arg_v;
    logic              arg_ovf;
    logic [DV_W-1:0]   vs_ext, ys_ext, dv_next;
    logic [DV_W-1:0]   mul_a;
    logic [H_W:0]      mul_b;
    logic signed [PROD_W-1:0] prod_full;
    logic [PROD_W-1:0] prod_rnd;
    logic [K_W-1:0]    k_rnd;
    logic [ACC_W-1:0]  add_y, add_v;
    logic [ACC_W-1:0]  quo_y, quo_v;
    logic              neg_y, neg_v, busy_y, busy_v;
    logic [SAT_W-1:0]  upd_x, upd_y, upd_v;
    logic              upd_ovf;

    // Stage arguments: y + k/2 (floor) for the middle stages, y + k for the last.
    assign off_y   = cmd.arg_full ? ky_reg : {ky_reg[K_W-1], ky_reg[K_W-1:1]};
    assign off_v   = cmd.arg_full ? kv_reg : {kv_reg[K_W-1], kv_reg[K_W-1:1]};
    assign arg_y   = ext_d(y_reg) + ext_k(off_y);
    assign arg_v   = ext_d(v_reg) + ext_k(off_v);
    assign arg_ovf = !fits(arg_y) || !fits(arg_v);

    // -2v - 5y, exact in DV_W bits.
    assign vs_ext  = {{(DV_W-DATA_W){vs_reg[DATA_W-1]}}, vs_reg};
    assign ys_ext  = {{(DV_W-DATA_W){ys_reg[DATA_W-1]}}, ys_reg};
    assign dv_next = DV_W'(0) - ({vs_ext[DV_W-2:0], 1'b0}
                                + {ys_ext[DV_W-3:0], 2'b00} + ys_ext);

    // The one shared multiplier: h times the velocity argument or the derivative.
    assign mul_a     = cmd.muld ? dv_reg : vs_ext;
    assign mul_b     = {1'b0, step_size};
    assign prod_full = $signed(mul_a) * $signed(mul_b);

    // Round half up, then floor shift.
    assign prod_rnd = prod_reg + ROUND_HALF;
    assign k_rnd    = prod_rnd[PROD_W-1:FRAC_BITS];

    assign add_y = cmd.acc_double ? {{(ACC_EXT-1){ky_reg[K_W-1]}}, ky_reg, 1'b0}
                                  : {{ACC_EXT{ky_reg[K_W-1]}}, ky_reg};
    assign add_v = cmd.acc_double ? {{(ACC_EXT-1){kv_reg[K_W-1]}}, kv_reg, 1'b0}
                                  : {{ACC_EXT{kv_reg[K_W-1]}}, kv_reg};

    rk4do_div6 #(
        .OPND_W (ACC_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (accy_reg),
        .quotient (quo_y),
        .negative (neg_y),
        .busy     (busy_y)
    );

    rk4do_div6 #(
        .OPND_W (ACC_W)
    ) u_div_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (accv_reg),
        .quotient (quo_v),
        .negative (neg_v),
        .busy     (busy_v)
    );

    assign status.div_busy = busy_y || busy_v;

    // The quotient is a magnitude, so the sign picks add or subtract.
    assign upd_y = neg_y ? ext_d(y_reg) - {{(SAT_W-ACC_W){1'b0}}, quo_y}
                         : ext_d(y_reg) + {{(SAT_W-ACC_W){1'b0}}, quo_y};
    assign upd_v = neg_v ? ext_d(v_reg) - {{(SAT_W-ACC_W){1'b0}}, quo_v}
                         : ext_d(v_reg) + {{(SAT_W-ACC_W){1'b0}}, quo_v};
    assign upd_x = ext_d(x_reg) + {{(SAT_W-H_W){1'b0}}, step_size};
    assign upd_ovf = !fits(upd_x) || !fits(upd_y) || !fits(upd_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            v_reg   <= '0;
            idx_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (restart)
            begin
                x_reg   <= start_x;
                y_reg   <= start_y;
                v_reg   <= start_v;
                idx_reg <= '0;
            end
            ovf_reg <= 1'b0;
        end
        else if (cmd.arg)
        begin
            ovf_reg <= ovf_reg || arg_ovf;
        end
        else if (cmd.commit)
        begin
            x_reg   <= sat(upd_x);
            y_reg   <= sat(upd_y);
            v_reg   <= sat(upd_v);
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ky_reg   <= '0;
            kv_reg   <= '0;
            accy_reg <= '0;
            accv_reg <= '0;
        end
        else
        begin
            if (cmd.acc_en)
            begin
                accy_reg <= accy_reg + add_y;
                accv_reg <= accv_reg + add_v;
            end
            if (cmd.muld)
                ky_reg <= k_rnd;
            if (cmd.kcap)
                kv_reg <= k_rnd;
        end

        if (cmd.arg)
        begin
            ys_reg <= sat(arg_y);
            vs_reg <= sat(arg_v);
        end
        if (cmd.mulv)
            dv_reg <= dv_next;
        if (cmd.mulv || cmd.muld)
            prod_reg <= prod_full;

        if (cmd.commit)
        begin
            point_x_reg  <= x_reg;
            point_y_reg  <= y_reg;
            point_v_reg  <= v_reg;
            final_reg    <= (idx_reg == step_count);
            overflow_reg <= ovf_reg || upd_ovf;
        end
    end

    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_v     = point_v_reg;
    assign final_point = final_reg;
    assign overflow    = overflow_reg;

endmodule

`default_nettype wire

// File: design/rk4do_ctrl.sv
// ----------------------------------------------------------------------------
// rk4do_ctrl
// Sequencer of the RK4 stepper: walks the four stages over the shared
// multiplier, runs the divide step and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4do_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire rk4do_pkg::dp_status_t status,
    output rk4do_pkg::dp_cmd_t         cmd
);
    import rk4do_pkg::*;

    state_t state_reg, state_next;
    stage_t stage_reg, stage_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= STG_K1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    stage_next = STG_K1;
                    state_next = ST_ARG;
                end
            end
            ST_ARG:
            begin
                // The k pair of the previous stage joins the weighted sums here.
                cmd.arg        = 1'b1;
                cmd.arg_full   = (stage_reg == STG_K4);
                cmd.acc_en     = 1'b1;
                cmd.acc_double = (stage_reg == STG_K3) || (stage_reg == STG_K4);
                state_next     = ST_MULV;
            end
            ST_MULV:
            begin
                cmd.mulv   = 1'b1;
                state_next = ST_MULD;
            end
            ST_MULD:
            begin
                cmd.muld   = 1'b1;
                state_next = ST_KCAP;
            end
            ST_KCAP:
            begin
                cmd.kcap = 1'b1;
                if (stage_reg == STG_K4)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    stage_next = stage_t'(stage_reg + 2'd1);
                    state_next = ST_ARG;
                end
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (!status.div_busy)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // Hold until the result register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: bench/rk4_point_checker.sv
// ----------------------------------------------------------------------------
// rk4_point_checker
// Predicts and checks every point of the RK4 damped-oscillator stepper.
// ----------------------------------------------------------------------------
// The checker watches register writes on the APB port and transfers on the
// input and output channels. It keeps its own copy of the configuration and
// the integrator state. For each input transfer it integrates one step in
// 64-bit arithmetic and queues the point that the block must return. Every
// output transfer is compared field by field with the oldest queued point.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_point_checker
    import rk4do_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic                        pready,
    input  wire logic [ADDR_W-1:0]           paddr,
    input  wire logic [PDATA_W-1:0]          pwdata,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        restart,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic signed [DATA_W-1:0]    point_x,
    input  wire logic signed [DATA_W-1:0]    point_y,
    input  wire logic signed [DATA_W-1:0]    point_v,
    input  wire logic                        final_point,
    input  wire logic                        overflow,
    output int                               errors,
    output int                               outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint MAX32      = 64'sd2147483647;
    localparam longint MIN32      = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] v;
        logic                     fin;
        logic                     ovf;
    } point_t;

    // Configuration copy, tracked from the register writes.
    logic        [H_W-1:0]    cfg_h;
    logic signed [DATA_W-1:0] cfg_x0;
    logic signed [DATA_W-1:0] cfg_y0;
    logic signed [DATA_W-1:0] cfg_v0;
    logic        [CNT_W-1:0]  cfg_n;

    // Integrator state.
    longint                   cur_x;
    longint                   cur_y;
    longint                   cur_v;
    logic        [CNT_W-1:0]  tick_idx;

    point_t                   expected_points[$];
    int                       mismatches = 0;

    assign errors = mismatches;

    function automatic longint clamp32(input longint a, inout logic ovf);
        if (a > MAX32)
        begin
            ovf = 1'b1;
            return MAX32;
        end
        if (a < MIN32)
        begin
            ovf = 1'b1;
            return MIN32;
        end
        return a;
    endfunction

    // h * a with round half up; the arithmetic shift floors.
    function automatic longint scale_by_h(input longint h, input longint a);
        return (h * a + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic longint accel(input longint y, input longint v);
        return -(2 * v) - 5 * y;
    endfunction

    // Division by six, rounding to nearest with ties away from zero.
    function automatic longint div6_round(input longint s);
        if (s >= 0)
            return (s + 3) / 6;
        return -((-s + 3) / 6);
    endfunction

    function automatic point_t predict_tick(input logic reload);
        point_t p;
        logic   ovf;
        longint h;
        longint y;
        longint v;
        longint ys;
        longint vs;
        longint k1y;
        longint k1v;
        longint k2y;
        longint k2v;
        longint k3y;
        longint k3v;
        longint k4y;
        longint k4v;

        if (reload)
        begin
            cur_x    = cfg_x0;
            cur_y    = cfg_y0;
            cur_v    = cfg_v0;
            tick_idx = '0;
        end

        p.x   = cur_x[DATA_W-1:0];
        p.y   = cur_y[DATA_W-1:0];
        p.v   = cur_v[DATA_W-1:0];
        p.fin = (tick_idx == cfg_n);

        ovf = 1'b0;
        h   = longint'(cfg_h);
        y   = cur_y;
        v   = cur_v;

        k1y = scale_by_h(h, v);
        k1v = scale_by_h(h, accel(y, v));

        ys  = clamp32(y + (k1y >>> 1), ovf);
        vs  = clamp32(v + (k1v >>> 1), ovf);
        k2y = scale_by_h(h, vs);
        k2v = scale_by_h(h, accel(ys, vs));

        ys  = clamp32(y + (k2y >>> 1), ovf);
        vs  = clamp32(v + (k2v >>> 1), ovf);
        k3y = scale_by_h(h, vs);
        k3v = scale_by_h(h, accel(ys, vs));

        // The last stage takes the whole of k3, not half of it.
        ys  = clamp32(y + k3y, ovf);
        vs  = clamp32(v + k3v, ovf);
        k4y = scale_by_h(h, vs);
        k4v = scale_by_h(h, accel(ys, vs));

        cur_y    = clamp32(y + div6_round(k1y + 2 * k2y + 2 * k3y + k4y), ovf);
        cur_v    = clamp32(v + div6_round(k1v + 2 * k2v + 2 * k3v + k4v), ovf);
        cur_x    = clamp32(cur_x + h, ovf);
        tick_idx = tick_idx + 1'b1;

        p.ovf = ovf;
        return p;
    endfunction

    task automatic compare_point();
        point_t want;
        point_t got;

        got = '{x: point_x, y: point_y, v: point_v, fin: final_point, ovf: overflow};
        if (expected_points.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: unexpected result transfer x=%0d y=%0d v=%0d final=%0b ovf=%0b",
                         $realtime, got.x, got.y, got.v, got.fin, got.ovf);
            mismatches++;
        end
        else
        begin
            want = expected_points.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.v !== want.v ||
                got.fin !== want.fin || got.ovf !== want.ovf)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: point mismatch", $realtime);
                    $display("    expected x=%0d y=%0d v=%0d final=%0b ovf=%0b",
                             want.x, want.y, want.v, want.fin, want.ovf);
                    $display("    actual   x=%0d y=%0d v=%0d final=%0b ovf=%0b",
                             got.x, got.y, got.v, got.fin, got.ovf);
                end
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_h    = STEP_SIZE_RST;
            cfg_x0   = START_X_RST;
            cfg_y0   = START_Y_RST;
            cfg_v0   = START_V_RST;
            cfg_n    = STEP_COUNT_RST;
            cur_x    = 0;
            cur_y    = 0;
            cur_v    = 0;
            tick_idx = '0;
            expected_points.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_STEP_SIZE:  cfg_h  = pwdata[H_W-1:0];
                    REG_START_X:    cfg_x0 = pwdata[DATA_W-1:0];
                    REG_START_Y:    cfg_y0 = pwdata[DATA_W-1:0];
                    REG_START_V:    cfg_v0 = pwdata[DATA_W-1:0];
                    REG_STEP_COUNT: cfg_n  = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                compare_point();
            if (in_valid && in_ready)
                expected_points.push_back(predict_tick(restart));
            outstanding <= expected_points.size();
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_rk4_damped_oscillator_step_top.sv
// ----------------------------------------------------------------------------
// tb_rk4_damped_oscillator_step_top
// Regression bench for the RK4 damped-oscillator stepper.
// ----------------------------------------------------------------------------
// A directed run covers the reset state, restart, the step-size extremes
// (zero, one LSB, 1.0 and the largest value), saturation of every state
// variable and the final-point flag. Random phases follow, each with a fresh
// register setting and a run of ticks with occasional restarts. Both channels
// idle at random; the receiver once holds off for a long stretch and the
// sender once drains the block mid-phase. Checking is done by the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rk4_damped_oscillator_step_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rk4do_pkg::*;

    localparam int unsigned FRAC        = 16;
    localparam int          RANDOM_TICKS = 800;
    localparam int          SETTLE      = 40;
    localparam int          HOLD_AT     = 300;
    localparam int          HOLD_CYCLES = 500;
    localparam int          IDLE_LIMIT  = 4000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [ADDR_W-1:0]        paddr     = '0;
    logic [PDATA_W-1:0]       pwdata    = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic                     restart   = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_v;
    logic                     final_point;
    logic                     overflow;

    int                       errors;
    int                       outstanding;
    int                       idle_cycles = 0;
    bit                       quiet       = 1'b0;

    always #10 clk = ~clk;

    rk4_damped_oscillator_step_top #(
        .FRAC_BITS (FRAC)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_v     (point_v),
        .final_point (final_point),
        .overflow    (overflow)
    );

    rk4_point_checker #(
        .FRAC_BITS (FRAC)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_v     (point_v),
        .final_point (final_point),
        .overflow    (overflow),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rk4_damped_oscillator_step_top regression: fail");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off once enough results
    // have been taken, so that the block backs up into its input channel.
    initial
    begin : result_side
        int taken;

        taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (taken == HOLD_AT)
            begin
                taken++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // Offers one tick and returns at the edge at which it is transferred.
    task automatic send_tick(input logic reload);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom);
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= reload;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic program_setting(input logic [H_W-1:0] h, input logic [DATA_W-1:0] x0,
                                   input logic [DATA_W-1:0] y0,
                                   input logic [DATA_W-1:0] v0,
                                   input logic [CNT_W-1:0] n);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        reg_write(REG_STEP_SIZE, PDATA_W'(h));
        reg_write(REG_START_X, x0);
        reg_write(REG_START_Y, y0);
        reg_write(REG_START_V, v0);
        reg_write(REG_STEP_COUNT, PDATA_W'(n));
    endtask

    function automatic logic [DATA_W-1:0] pick_start();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            default: return 32'(int'($urandom_range(1048576)) - 524288);
        endcase
    endfunction

    initial
    begin : stimulus
        int               sent;
        int               phase;
        int               run_len;
        int               i;
        logic [H_W-1:0]   h;
        logic [CNT_W-1:0] n;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state first, then a restart from the reset start values.
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // Step 1.0 from extreme starting values: saturation everywhere.
        program_setting(17'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd2);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);

        // Largest step size with x near its top: x saturates.
        program_setting('1, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);

        // Zero step: the state holds, only the step index moves.
        program_setting('0, 32'h1234_5678, 32'h0003_0000, 32'hFFFE_0000, 16'd1);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // Smallest nonzero step.
        program_setting(17'd1, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000, 16'd0);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_TICKS)
        begin
            case ($urandom_range(9))
                0:       h = '0;
                1:       h = 17'd1;
                2:       h = 17'd65536;
                3:       h = '1;
                4:       h = 17'($urandom);
                default: h = 17'($urandom_range(20000, 300));
            endcase
            n = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(60));
            program_setting(h, pick_start(), pick_start(), pick_start(), n);
            quiet   = (phase == 3);
            run_len = $urandom_range(120, 20);
            send_tick(1'b1);
            sent++;
            for (i = 1; i < run_len; i++)
            begin
                if (phase == 2 && i == 30)
                    wait_drained();
                send_tick($urandom_range(99) < 4);
                sent++;
            end
            phase++;
        end
        quiet = 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("rk4_damped_oscillator_step_top regression: pass");
        else
            $display("rk4_damped_oscillator_step_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: rk4_damped_oscillator_step_top.f
design/rk4do_pkg.sv
design/rk4do_div6.sv
design/rk4do_dpath.sv
design/rk4do_ctrl.sv
design/rk4_damped_oscillator_step_top.sv
bench/rk4_point_checker.sv
bench/tb_rk4_damped_oscillator_step_top.sv
